FILE: src/rgba_alpha_unpremultiply_unit_assert.svh
// Assertion macros shared by the un-premultiply checker
`ifndef RGBA_ALPHA_UNPREMULTIPLY_UNIT_ASSERT_SVH
`define RGBA_ALPHA_UNPREMULTIPLY_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define RAU_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define RAU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/rau_pkg.sv
// Types, constants and reciprocal table for the alpha un-premultiply unit
package rau_pkg;

    localparam int CHAN_W     = 8;
    localparam int NUM_LANES  = 3;
    localparam int NUM_W      = 16;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W    = RECIP_SHIFT + 1;
    localparam int PROD_W     = NUM_W + RECIP_W;
    localparam int TABLE_SIZE = 1 << CHAN_W;

    localparam int MODE_W = 2;
    localparam logic [MODE_W-1:0] MODE_PASS      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNPREMUL  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RESERVED  = 2'd3;

    localparam logic [CHAN_W-1:0] CHAN_MAX  = 8'd255;
    localparam logic [CHAN_W-1:0] CHAN_ZERO = 8'd0;

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [RECIP_W-1:0] recip_t;
    typedef logic [MODE_W-1:0]  mode_t;
    typedef recip_t recip_table_t [TABLE_SIZE];

    typedef struct packed {
        logic s1_load;
        logic s2_load;
    } lane_ctrl_t;

    typedef struct packed {
        chan_t orig;
        chan_t quot;
        logic  sat;
    } lane_res_t;

    typedef struct packed {
        logic  zero;
        logic  expand;
        chan_t alpha;
        logic  last;
    } pix_flags_t;

    // ceil(2^RECIP_SHIFT / d) by restoring division, evaluated at elaboration
    function automatic recip_table_t build_recip();
        recip_table_t tbl;
        longint unsigned rem;
        longint unsigned quo;
        int d;
        int i;
        for (d = 0; d < TABLE_SIZE; d++)
        begin
            rem = 0;
            quo = 0;
            for (i = RECIP_SHIFT; i >= 0; i--)
            begin
                rem = (rem << 1) | ((i == RECIP_SHIFT) ? 64'd1 : 64'd0);
                quo = quo << 1;
                if (d != 0 && rem >= longint'(d))
                begin
                    rem = rem - longint'(d);
                    quo = quo | 64'd1;
                end
            end
            if (d == 0)
            begin
                tbl[d] = '0;
            end
            else
            begin
                tbl[d] = RECIP_W'(quo + ((rem != 0) ? 64'd1 : 64'd0));
            end
        end
        return tbl;
    endfunction

    localparam recip_table_t RECIP_TABLE = build_recip();

endpackage

FILE: src/rau_if.sv
// Pixel channel interfaces: premultiplied input and straight-alpha output
interface rau_premul_if;
    logic               valid;
    logic               ready;
    rau_pkg::chan_t     in_red;
    rau_pkg::chan_t     in_green;
    rau_pkg::chan_t     in_blue;
    rau_pkg::chan_t     in_alpha;
    logic               in_last_pixel;

    modport source (
        output valid, in_red, in_green, in_blue, in_alpha, in_last_pixel,
        input  ready
    );
    modport sink (
        input  valid, in_red, in_green, in_blue, in_alpha, in_last_pixel,
        output ready
    );
endinterface

interface rau_straight_if;
    logic               valid;
    logic               ready;
    rau_pkg::chan_t     out_red;
    rau_pkg::chan_t     out_green;
    rau_pkg::chan_t     out_blue;
    rau_pkg::chan_t     out_alpha;
    logic               out_last_pixel;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha, out_last_pixel,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha, out_last_pixel,
        output ready
    );
endinterface

FILE: src/rau_lane.sv
// One colour lane: numerator build, then reciprocal multiply
module rau_lane (
    input  logic                clk,
    input  rau_pkg::lane_ctrl_t ctrl,
    input  rau_pkg::chan_t      chan,
    input  rau_pkg::chan_t      alpha,
    input  rau_pkg::recip_t     recip,
    output rau_pkg::lane_res_t  res
);

    rau_pkg::num_t  num_reg;
    logic           sat1_reg;
    rau_pkg::chan_t orig1_reg;

    logic           sat2_reg;
    rau_pkg::chan_t orig2_reg;
    rau_pkg::chan_t quot_reg;

    rau_pkg::num_t  num_next;
    logic [rau_pkg::PROD_W-1:0] prod;

    // c*255 + floor(a/2); at most 16 bits for any 8-bit inputs
    assign num_next = rau_pkg::num_t'(chan) * rau_pkg::num_t'(rau_pkg::CHAN_MAX)
                    + rau_pkg::num_t'(alpha[rau_pkg::CHAN_W-1:1]);

    assign prod = rau_pkg::PROD_W'(num_reg) * rau_pkg::PROD_W'(recip);

    always_ff @(posedge clk)
    begin
        if (ctrl.s1_load)
        begin
            num_reg   <= num_next;
            // a channel at or above alpha expands to full scale or past it
            sat1_reg  <= (chan >= alpha);
            orig1_reg <= chan;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.s2_load)
        begin
            quot_reg  <= prod[rau_pkg::RECIP_SHIFT +: rau_pkg::CHAN_W];
            sat2_reg  <= sat1_reg;
            orig2_reg <= orig1_reg;
        end
    end

    assign res.orig = orig2_reg;
    assign res.quot = quot_reg;
    assign res.sat  = sat2_reg;

endmodule

FILE: src/rau_merge.sv
// Output stage: picks each lane's result and holds the word for the receiver
module rau_merge (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  rau_pkg::pix_flags_t   flags,
    input  rau_pkg::lane_res_t    res [rau_pkg::NUM_LANES],
    output logic                  can_take,
    rau_straight_if.source        straight
);

    logic           valid_reg;
    logic           valid_next;
    rau_pkg::chan_t chan_reg [rau_pkg::NUM_LANES];
    rau_pkg::chan_t chan_next [rau_pkg::NUM_LANES];
    rau_pkg::chan_t alpha_reg;
    logic           last_reg;

    assign can_take = !valid_reg || straight.ready;

    always_comb
    begin
        for (int k = 0; k < rau_pkg::NUM_LANES; k++)
        begin
            if (flags.zero)
            begin
                chan_next[k] = rau_pkg::CHAN_ZERO;
            end
            else if (flags.expand)
            begin
                chan_next[k] = res[k].sat ? rau_pkg::CHAN_MAX : res[k].quot;
            end
            else
            begin
                chan_next[k] = res[k].orig;
            end
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (straight.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            chan_reg  <= chan_next;
            alpha_reg <= flags.alpha;
            last_reg  <= flags.last;
        end
    end

    assign straight.valid          = valid_reg;
    assign straight.out_red        = chan_reg[rau_pkg::LANE_RED];
    assign straight.out_green      = chan_reg[rau_pkg::LANE_GREEN];
    assign straight.out_blue       = chan_reg[rau_pkg::LANE_BLUE];
    assign straight.out_alpha      = alpha_reg;
    assign straight.out_last_pixel = last_reg;

endmodule

FILE: src/rgba_alpha_unpremultiply_unit.sv
// Top level of the RGBA alpha un-premultiply unit
//
// Usage:
//   premul   - input channel, one premultiplied RGBA pixel per word with a
//              last-pixel flag; a word moves when valid and ready are high.
//   straight - output channel, the matching straight-alpha pixel per word.
//   cfg_we / cfg_wdata - alpha mode register; 2 turns un-premultiply on,
//              0 and 1 pass pixels through, a write of 3 is dropped.
//   Write the mode only while no pixel is in flight.
// A pixel passes reciprocal lookup and numerator, reciprocal multiply and lane
// merge into the output register, each step registered. Throughput is one
// pixel per cycle while straight.ready stays high, set by the three colour
// lanes each owning a 16x25 multiplier.
// Reset clears the mode to pass-through and empties every stage.
// When the receiver stalls, the output word holds; the pipe keeps filling
// its empty stages and lowers premul.ready once every stage is occupied.
module rgba_alpha_unpremultiply_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  rau_pkg::mode_t  cfg_wdata,
    rau_premul_if.sink      premul,
    rau_straight_if.source  straight
);

    rau_pkg::mode_t       mode_reg;
    rau_pkg::mode_t       mode_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    rau_pkg::pix_flags_t  s1_flags_reg;
    rau_pkg::recip_t      recip_reg;

    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    rau_pkg::pix_flags_t  s2_flags_reg;

    rau_pkg::pix_flags_t  flags_next;
    rau_pkg::lane_ctrl_t  lane_ctrl;
    rau_pkg::chan_t       lane_chan [rau_pkg::NUM_LANES];
    rau_pkg::lane_res_t   lane_res [rau_pkg::NUM_LANES];

    logic                 merge_can_take;
    logic                 s2_can_take;
    logic                 s1_can_take;
    logic                 in_fire;
    logic                 s1_move;
    logic                 s2_move;
    logic                 unpremul;

    // stage advance: a stage takes a word when it is empty or its word moves on
    assign s2_can_take = !s2_valid_reg || merge_can_take;
    assign s1_can_take = !s1_valid_reg || s2_can_take;
    assign s2_move     = s2_valid_reg && merge_can_take;
    assign s1_move     = s1_valid_reg && s2_can_take;
    assign in_fire     = premul.valid && s1_can_take;
    assign premul.ready = s1_can_take;

    assign lane_ctrl.s1_load = in_fire;
    assign lane_ctrl.s2_load = s1_move;

    assign unpremul = (mode_reg == rau_pkg::MODE_UNPREMUL);

    always_comb
    begin
        flags_next.zero   = unpremul && (premul.in_alpha == rau_pkg::CHAN_ZERO);
        flags_next.expand = unpremul && (premul.in_alpha != rau_pkg::CHAN_ZERO)
                            && (premul.in_alpha != rau_pkg::CHAN_MAX);
        flags_next.alpha  = premul.in_alpha;
        flags_next.last   = premul.in_last_pixel;
    end

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_we && (cfg_wdata != rau_pkg::MODE_RESERVED))
        begin
            mode_next = cfg_wdata;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_next = 1'b0;
        end

        s2_valid_next = s2_valid_reg;
        if (s1_move)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_move)
        begin
            s2_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= rau_pkg::MODE_PASS;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg     <= mode_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_flags_reg <= flags_next;
            recip_reg    <= rau_pkg::RECIP_TABLE[premul.in_alpha];
        end
        if (s1_move)
        begin
            s2_flags_reg <= s1_flags_reg;
        end
    end

    assign lane_chan[rau_pkg::LANE_RED]   = premul.in_red;
    assign lane_chan[rau_pkg::LANE_GREEN] = premul.in_green;
    assign lane_chan[rau_pkg::LANE_BLUE]  = premul.in_blue;

    for (genvar k = 0; k < rau_pkg::NUM_LANES; k++)
    begin : g_lane
        rau_lane u_lane (
            .clk   (clk),
            .ctrl  (lane_ctrl),
            .chan  (lane_chan[k]),
            .alpha (premul.in_alpha),
            .recip (recip_reg),
            .res   (lane_res[k])
        );
    end

    rau_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (s2_move),
        .flags    (s2_flags_reg),
        .res      (lane_res),
        .can_take (merge_can_take),
        .straight (straight)
    );

endmodule

FILE: src/rau_checker.sv
// Port-level checker for the un-premultiply unit, with its bind
`include "rgba_alpha_unpremultiply_unit_assert.svh"

module rau_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  rau_pkg::mode_t  cfg_wdata,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic            out_valid,
    input  logic            out_ready,
    input  rau_pkg::chan_t  out_red,
    input  rau_pkg::chan_t  out_green,
    input  rau_pkg::chan_t  out_blue,
    input  rau_pkg::chan_t  out_alpha,
    input  logic            out_last_pixel
);

    rau_pkg::mode_t mode_reg;
    rau_pkg::mode_t mode_next;
    logic [2:0]     pending_reg;
    logic [2:0]     pending_next;
    logic           in_fire;
    logic           out_fire;
    logic           out_stall;
    logic [4*rau_pkg::CHAN_W:0] out_word;
    logic           clear_word;
    logic           black_word;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign out_stall = out_valid && !out_ready;
    assign out_word  = {out_red, out_green, out_blue, out_alpha, out_last_pixel};
    assign clear_word = out_valid && (mode_reg == rau_pkg::MODE_UNPREMUL)
                        && (out_alpha == rau_pkg::CHAN_ZERO);
    assign black_word = (out_red == rau_pkg::CHAN_ZERO) && (out_green == rau_pkg::CHAN_ZERO)
                        && (out_blue == rau_pkg::CHAN_ZERO);

    always_comb
    begin
        mode_next = mode_reg;
        if (cfg_we && (cfg_wdata != rau_pkg::MODE_RESERVED))
        begin
            mode_next = cfg_wdata;
        end
        pending_next = pending_reg + 3'(in_fire) - 3'(out_fire);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= rau_pkg::MODE_PASS;
            pending_reg <= 3'd0;
        end
        else
        begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
        end
    end

    `RAU_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_stall, out_valid,
        "output word dropped while stalled")

    `RAU_ASSERT_NEXT(a_out_payload_hold, clk, rst_n, out_stall, $stable(out_word),
        "output word changed while stalled")

    `RAU_ASSERT_NOW(a_no_orphan_word, clk, rst_n, out_valid, pending_reg != 3'd0,
        "output word with no pixel in flight")

    `RAU_ASSERT_NOW(a_clear_is_black, clk, rst_n, clear_word, black_word,
        "transparent pixel kept colour")

endmodule

bind rgba_alpha_unpremultiply_unit rau_checker u_rau_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (premul.valid),
    .in_ready       (premul.ready),
    .out_valid      (straight.valid),
    .out_ready      (straight.ready),
    .out_red        (straight.out_red),
    .out_green      (straight.out_green),
    .out_blue       (straight.out_blue),
    .out_alpha      (straight.out_alpha),
    .out_last_pixel (straight.out_last_pixel)
);

FILE: dv/rau_unpremul_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the alpha un-premultiply unit: predicts every straight-alpha word and compares
module rau_unpremul_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_we,
    input  rau_pkg::mode_t cfg_wdata,
    rau_premul_if          premul,
    rau_straight_if        straight,
    output int             mismatch_count,
    output int             pixels_in_flight
);
    import rau_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
        logic  last;
    } pixel_t;

    mode_t  mode_shadow = MODE_PASS;
    pixel_t straight_expected [$];
    int     mismatches = 0;
    int     in_flight = 0;
    int     words_seen = 0;

    assign mismatch_count   = mismatches;
    assign pixels_in_flight = in_flight;

    // c*255/a rounded to nearest, clamped where the channel exceeds alpha
    function automatic chan_t expand_lane(chan_t c, chan_t a);
        int unsigned v;
        v = (32'(c) * 32'(CHAN_MAX) + 32'(a) / 32'd2) / 32'(a);
        return (v > 32'(CHAN_MAX)) ? CHAN_MAX : chan_t'(v);
    endfunction

    function automatic pixel_t unpremultiply(pixel_t p, mode_t m);
        pixel_t q;
        q = p;
        if (m == MODE_UNPREMUL)
        begin
            if (p.alpha == CHAN_ZERO)
            begin
                q.red   = CHAN_ZERO;
                q.green = CHAN_ZERO;
                q.blue  = CHAN_ZERO;
            end
            else if (p.alpha != CHAN_MAX)
            begin
                q.red   = expand_lane(p.red, p.alpha);
                q.green = expand_lane(p.green, p.alpha);
                q.blue  = expand_lane(p.blue, p.alpha);
            end
        end
        return q;
    endfunction

    task automatic flag_mismatch(string what, pixel_t exp_px, pixel_t got_px);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $write("[%0t] %s at word %0d: expected r=%0d g=%0d b=%0d a=%0d last=%0b,",
                   $time, what, words_seen, exp_px.red, exp_px.green, exp_px.blue,
                   exp_px.alpha, exp_px.last);
            $display(" got r=%0d g=%0d b=%0d a=%0d last=%0b",
                     got_px.red, got_px.green, got_px.blue, got_px.alpha, got_px.last);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t got_px;
        pixel_t exp_px;
        pixel_t in_px;
        if (!rst_n)
        begin
            mode_shadow = MODE_PASS;
            straight_expected.delete();
            in_flight = 0;
        end
        else
        begin
            if (straight.valid && straight.ready)
            begin
                got_px = '{straight.out_red, straight.out_green, straight.out_blue,
                           straight.out_alpha, straight.out_last_pixel};
                if (straight_expected.size() == 0)
                begin
                    flag_mismatch("unexpected word", '0, got_px);
                end
                else
                begin
                    exp_px = straight_expected.pop_front();
                    if (got_px.red !== exp_px.red || got_px.green !== exp_px.green ||
                        got_px.blue !== exp_px.blue || got_px.alpha !== exp_px.alpha ||
                        got_px.last !== exp_px.last)
                    begin
                        flag_mismatch("pixel mismatch", exp_px, got_px);
                    end
                end
                words_seen++;
            end
            if (premul.valid && premul.ready)
            begin
                in_px = '{premul.in_red, premul.in_green, premul.in_blue,
                          premul.in_alpha, premul.in_last_pixel};
                straight_expected.push_back(unpremultiply(in_px, mode_shadow));
            end
            // a write of the reserved code leaves the mode as it was
            if (cfg_we && cfg_wdata != MODE_RESERVED)
            begin
                mode_shadow = cfg_wdata;
            end
            in_flight = straight_expected.size();
        end
    end

endmodule

FILE: dv/tb_rgba_alpha_unpremultiply_unit.sv
`timescale 1ns / 1ps
// Testbench top for the alpha un-premultiply unit: clock, reset, pixel stimulus and verdict
module tb_rgba_alpha_unpremultiply_unit;
    import rau_pkg::*;

    localparam mode_t MODE_PASS_ALT  = 2'd1;
    localparam int    SETTLE_CYCLES  = 8;
    localparam int    SEGMENT_PIXELS = 62;
    localparam int    RESET_CYCLES   = 10;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_we;
    mode_t cfg_wdata;
    int    send_idle_pct;
    int    recv_idle_pct;
    int    mismatch_count;
    int    pixels_in_flight;

    rau_premul_if   premul ();
    rau_straight_if straight ();

    rgba_alpha_unpremultiply_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .premul    (premul),
        .straight  (straight)
    );

    rau_unpremul_checker i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .premul           (premul),
        .straight         (straight),
        .mismatch_count   (mismatch_count),
        .pixels_in_flight (pixels_in_flight)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        straight.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_pixel(chan_t r, chan_t g, chan_t b, chan_t a, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            premul.valid <= 1'b0;
            @(posedge clk);
        end
        premul.valid         <= 1'b1;
        premul.in_red        <= r;
        premul.in_green      <= g;
        premul.in_blue       <= b;
        premul.in_alpha      <= a;
        premul.in_last_pixel <= last;
        do
            @(posedge clk);
        while (!premul.ready);
    endtask

    // mostly well-formed premultiplied pixels (colour no larger than alpha)
    task automatic send_random_pixel();
        chan_t a;
        chan_t c [3];
        logic  last;
        case ($urandom_range(9))
            0:       a = CHAN_ZERO;
            1:       a = CHAN_MAX;
            2:       a = 8'd1;
            3:       a = 8'd254;
            default: a = chan_t'($urandom_range(255));
        endcase
        for (int k = 0; k < 3; k++)
        begin
            if ($urandom_range(9) < 7)
                c[k] = chan_t'($urandom_range(a));
            else
                c[k] = chan_t'($urandom_range(255));
        end
        last = ($urandom_range(15) == 0);
        send_pixel(c[0], c[1], c[2], a, last);
    endtask

    // hold the sender until every expected word has come out
    task automatic drain_pipe();
        premul.valid <= 1'b0;
        @(posedge clk);
        while (pixels_in_flight != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(mode_t m);
        drain_pipe();
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        mode_t next_mode;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = MODE_PASS;
        premul.valid         = 1'b0;
        premul.in_red        = '0;
        premul.in_green      = '0;
        premul.in_blue       = '0;
        premul.in_alpha      = '0;
        premul.in_last_pixel = 1'b0;
        send_idle_pct        = 20;
        recv_idle_pct        = 76;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through straight out of reset
        send_pixel(8'd255, 8'd0, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd255, 8'd0, 8'd128, 1'b0);
        send_pixel(8'd200, 8'd17, 8'd90, 8'd100, 1'b0);

        write_mode(MODE_UNPREMUL);
        send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd0, 1'b1);
        send_pixel(8'd0, 8'd128, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd1, 8'd255, 8'd1, 1'b0);
        send_pixel(8'd254, 8'd253, 8'd127, 8'd254, 1'b1);
        send_pixel(8'd64, 8'd1, 8'd127, 8'd128, 1'b0);
        send_pixel(8'd1, 8'd2, 8'd3, 8'd2, 1'b0);
        send_pixel(8'd1, 8'd2, 8'd3, 8'd3, 1'b0);
        send_pixel(8'd50, 8'd99, 8'd100, 8'd100, 1'b1);
        send_pixel(8'd16, 8'd0, 8'd255, 8'd17, 1'b0);
        send_pixel(8'd85, 8'd42, 8'd43, 8'd85, 1'b0);
        send_pixel(8'd199, 8'd201, 8'd255, 8'd200, 1'b1);
        send_pixel(8'h55, 8'hAA, 8'h55, 8'hAA, 1'b0);
        send_pixel(8'hAA, 8'h55, 8'hAA, 8'h55, 1'b1);

        // reserved code must be dropped, un-premultiply stays on
        write_mode(MODE_RESERVED);
        send_pixel(8'd10, 8'd20, 8'd30, 8'd40, 1'b0);
        send_pixel(8'd60, 8'd5, 8'd128, 8'd64, 1'b1);

        write_mode(MODE_PASS_ALT);
        send_pixel(8'd200, 8'd100, 8'd50, 8'd25, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 8'd1, 1'b1);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 20;
                    recv_idle_pct = 76;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_idle_pct = 20;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                case ($urandom_range(5))
                    0:       next_mode = MODE_PASS;
                    1:       next_mode = MODE_PASS_ALT;
                    2:       next_mode = MODE_RESERVED;
                    default: next_mode = MODE_UNPREMUL;
                endcase
                write_mode(next_mode);
                repeat (SEGMENT_PIXELS) send_random_pixel();
            end
        end

        drain_pipe();
        if (mismatch_count == 0 && pixels_in_flight == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
